### sv/circle_point_in_plane_assert.svh
// Assertion macros for the circle point block.
// Included by the modules that check their own control logic.
`ifndef CIRCLE_POINT_IN_PLANE_ASSERT_SVH
`define CIRCLE_POINT_IN_PLANE_ASSERT_SVH
`ifndef SYNTHESIS
`define CPIP_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: %m");
`define CPIP_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: %m");
`else
`define CPIP_ASSERT_IMP(label, clk, rst, pre, post)
`define CPIP_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

### sv/cpip_pkg.sv
// Shared types, widths and constants of the circle point block.
// No dependencies.
package cpip_pkg;

   localparam int ANGLE_W = 16;
   localparam int COORD_W = 32;
   localparam int NORM_W  = 16;
   localparam int UNIT_W  = 32;
   localparam int CORD_W  = 34;
   localparam int PHASE_W = 32;
   localparam int PROD_W  = 67;
   localparam int RC_W    = 37;
   localparam int TPROD_W = 69;
   localparam int TERM_W  = 39;
   localparam int SUM_W   = 41;

   localparam logic signed [CORD_W-1:0] INV_GAIN = 34'sd652032874;
   localparam logic signed [UNIT_W-1:0] ONE_Q30  = 32'sd1073741824;

   localparam logic [2:0] CSR_CENTER_X = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y = 3'd1;
   localparam logic [2:0] CSR_CENTER_Z = 3'd2;
   localparam logic [2:0] CSR_NORMAL_X = 3'd3;
   localparam logic [2:0] CSR_NORMAL_Y = 3'd4;
   localparam logic [2:0] CSR_NORMAL_Z = 3'd5;
   localparam logic [2:0] CSR_RADIUS   = 3'd6;

   typedef struct packed {
      logic                      vld;
      logic [1:0]                quad;
      logic signed [CORD_W-1:0]  x;
      logic signed [CORD_W-1:0]  y;
      logic signed [PHASE_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic signed [UNIT_W-1:0] ax_x;
      logic signed [UNIT_W-1:0] ax_y;
      logic signed [UNIT_W-1:0] ax_z;
      logic signed [UNIT_W-1:0] ay_x;
      logic signed [UNIT_W-1:0] ay_y;
      logic signed [UNIT_W-1:0] ay_z;
   } basis_type;

   function automatic logic signed [PHASE_W-1:0] atan_val(input int i);
      logic signed [PHASE_W-1:0] r;
      case (i)
         0: r = 32'sd536870912;
         1: r = 32'sd316933406;
         2: r = 32'sd167458907;
         3: r = 32'sd85004756;
         4: r = 32'sd42667331;
         5: r = 32'sd21354465;
         6: r = 32'sd10679838;
         7: r = 32'sd5340245;
         8: r = 32'sd2670163;
         9: r = 32'sd1335087;
         10: r = 32'sd667544;
         11: r = 32'sd333772;
         12: r = 32'sd166886;
         13: r = 32'sd83443;
         14: r = 32'sd41722;
         15: r = 32'sd20861;
         16: r = 32'sd10431;
         17: r = 32'sd5215;
         18: r = 32'sd2608;
         19: r = 32'sd1304;
         20: r = 32'sd652;
         21: r = 32'sd326;
         22: r = 32'sd163;
         23: r = 32'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### sv/cpip_cordic_cell.sv
// One rotation-mode CORDIC cell of the sine/cosine chain.
// Depends on cpip_pkg.
module cpip_cordic_cell
   import cpip_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  cordic_type d_in,
   output cordic_type d_out
);

   localparam logic signed [PHASE_W-1:0] ATAN = atan_val(SHIFT);

   logic                      vld_ff;
   logic [1:0]                quad_ff;
   logic signed [CORD_W-1:0]  x_ff, y_ff, x_in, y_in;
   logic signed [PHASE_W-1:0] z_ff, z_in;
   logic signed [CORD_W-1:0]  xs, ys;

   always_comb begin
      xs = d_in.x >>> SHIFT;
      ys = d_in.y >>> SHIFT;
      if (!d_in.z[PHASE_W-1]) begin
         x_in = d_in.x - ys;
         y_in = d_in.y + xs;
         z_in = d_in.z - ATAN;
      end else begin
         x_in = d_in.x + ys;
         y_in = d_in.y - xs;
         z_in = d_in.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= d_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff <= d_in.quad;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign d_out = '{vld: vld_ff, quad: quad_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

### sv/cpip_basis.sv
// Plane basis sequencer: normalizes helper-cross-normal and normal-cross-axis.
// Shared square, integer square root and bit-serial divider. Depends on cpip_pkg.
`include "circle_point_in_plane_assert.svh"
module cpip_basis
   import cpip_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cfg_write,
   input  logic signed [NORM_W-1:0] nx,
   input  logic signed [NORM_W-1:0] ny,
   input  logic signed [NORM_W-1:0] nz,
   output basis_type                basis,
   output logic                     ready
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_START = 11'b00000000010,
      S_SQN   = 11'b00000000100,
      S_HELP  = 11'b00000001000,
      S_PICK  = 11'b00000010000,
      S_LOAD  = 11'b00000100000,
      S_SHIFT = 11'b00001000000,
      S_SQ    = 11'b00010000000,
      S_SQRT  = 11'b00100000000,
      S_DIV   = 11'b01000000000,
      S_CROSS = 11'b10000000000
   } state_type;

   state_type               state_ff;
   logic                    ok_ff;
   logic                    which_ff;
   logic [31:0]             l2n_ff, z2n_ff;
   logic [51:0]             l2w_ff, z2w_ff;
   logic signed [16:0]      a_ff [3];
   logic signed [32:0]      v_ff [3];
   logic [31:0]             m_ff [3];
   logic [63:0]             acc_ff, bit_ff, res_ff;
   logic [31:0]             rem_ff;
   logic [30:0]             dbits_ff, q_ff;
   logic [1:0]              k_ff;
   logic [4:0]              cnt_ff;
   logic signed [UNIT_W-1:0] ax_ff [3];
   logic signed [UNIT_W-1:0] ay_ff [3];

   logic [31:0]        mx, len_w;
   logic [63:0]        trial, res_nx;
   logic [32:0]        t_div;
   logic               qbit;
   logic [30:0]        qfin;
   logic signed [31:0] uval;
   logic signed [32:0] b0, b1, b2;
   logic signed [31:0] sq_l2;

   always_comb begin
      mx = m_ff[0];
      if (m_ff[1] > mx) mx = m_ff[1];
      if (m_ff[2] > mx) mx = m_ff[2];
      trial  = res_ff + bit_ff;
      res_nx = (acc_ff >= trial) ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
      len_w  = (res_ff == '0) ? 32'd1 : res_ff[31:0];
      t_div  = {rem_ff, dbits_ff[30]};
      qbit   = (t_div >= {1'b0, len_w});
      qfin   = {q_ff[29:0], qbit};
      uval   = v_ff[k_ff][32] ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
      b0     = 33'(ny * a_ff[2]) - 33'(nz * a_ff[1]);
      b1     = 33'(nz * a_ff[0]) - 33'(nx * a_ff[2]);
      b2     = 33'(nx * a_ff[1]) - 33'(ny * a_ff[0]);
      sq_l2  = 32'(nx * nx) + 32'(ny * ny) + 32'(nz * nz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_START;
         ok_ff    <= 1'b0;
      end else if (cfg_write) begin
         state_ff <= S_START;
         ok_ff    <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               state_ff <= S_IDLE;
            end
            S_START: begin
               if (nx == '0 && ny == '0) begin
                  ok_ff    <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_SQN;
               end
            end
            S_SQN:   state_ff <= S_HELP;
            S_HELP:  state_ff <= S_PICK;
            S_PICK:  state_ff <= S_LOAD;
            S_LOAD:  state_ff <= S_SHIFT;
            S_SHIFT: begin
               if (mx == '0) begin
                  if (which_ff) begin
                     ok_ff    <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_CROSS;
                  end
               end else if (mx[31:30] != 2'b00) begin
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (k_ff == 2'd2) state_ff <= S_SQRT;
            end
            S_SQRT: begin
               if (bit_ff[0]) state_ff <= S_DIV;
            end
            S_DIV: begin
               if (cnt_ff == 5'd30 && k_ff == 2'd2) begin
                  if (which_ff) begin
                     ok_ff    <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_CROSS;
                  end
               end
            end
            S_CROSS: state_ff <= S_LOAD;
            default: state_ff <= S_START;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_START: begin
            ax_ff[0] <= ONE_Q30;
            ax_ff[1] <= '0;
            ax_ff[2] <= '0;
            ay_ff[0] <= '0;
            ay_ff[1] <= nz[NORM_W-1] ? -ONE_Q30 : ONE_Q30;
            ay_ff[2] <= '0;
            which_ff <= 1'b0;
         end
         S_SQN: begin
            l2n_ff <= sq_l2;
            z2n_ff <= 32'(nz * nz);
         end
         S_HELP: begin
            l2w_ff <= 52'(l2n_ff) * 52'd998001;
            z2w_ff <= 52'(z2n_ff) * 52'd1000000;
         end
         S_PICK: begin
            if (z2w_ff < l2w_ff) begin
               a_ff[0] <= -17'(ny);
               a_ff[1] <= 17'(nx);
               a_ff[2] <= '0;
               v_ff[0] <= -33'(ny);
               v_ff[1] <= 33'(nx);
               v_ff[2] <= '0;
            end else begin
               a_ff[0] <= 17'(nz);
               a_ff[1] <= '0;
               a_ff[2] <= -17'(nx);
               v_ff[0] <= 33'(nz);
               v_ff[1] <= '0;
               v_ff[2] <= -33'(nx);
            end
         end
         S_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               m_ff[i] <= v_ff[i][32] ? 32'(-v_ff[i]) : v_ff[i][31:0];
            end
         end
         S_SHIFT: begin
            if (mx == '0) begin
               if (which_ff) begin
                  ay_ff[0] <= '0;
                  ay_ff[1] <= ONE_Q30;
                  ay_ff[2] <= '0;
               end else begin
                  ax_ff[0] <= ONE_Q30;
                  ax_ff[1] <= '0;
                  ax_ff[2] <= '0;
               end
            end else if (mx[31:30] == 2'b00) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
            end else begin
               if (mx[31]) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
               end
               acc_ff <= '0;
               k_ff   <= 2'd0;
            end
         end
         S_SQ: begin
            acc_ff <= acc_ff + 64'(m_ff[k_ff]) * 64'(m_ff[k_ff]);
            if (k_ff == 2'd2) begin
               bit_ff <= 64'd1 << 62;
               res_ff <= '0;
            end else begin
               k_ff <= k_ff + 2'd1;
            end
         end
         S_SQRT: begin
            if (acc_ff >= trial) acc_ff <= acc_ff - trial;
            res_ff <= res_nx;
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               k_ff     <= 2'd0;
               rem_ff   <= {1'b0, m_ff[0][31:1]};
               dbits_ff <= {m_ff[0][0], 30'b0};
               q_ff     <= '0;
               cnt_ff   <= '0;
            end
         end
         S_DIV: begin
            if (cnt_ff == 5'd30) begin
               if (which_ff) ay_ff[k_ff] <= uval;
               else ax_ff[k_ff] <= uval;
            end
            if (cnt_ff == 5'd30 && k_ff != 2'd2) begin
               k_ff     <= k_ff + 2'd1;
               rem_ff   <= {1'b0, m_ff[k_ff + 2'd1][31:1]};
               dbits_ff <= {m_ff[k_ff + 2'd1][0], 30'b0};
               q_ff     <= '0;
               cnt_ff   <= '0;
            end else begin
               rem_ff   <= qbit ? 32'(t_div - {1'b0, len_w}) : t_div[31:0];
               q_ff     <= qfin;
               dbits_ff <= dbits_ff << 1;
               cnt_ff   <= cnt_ff + 5'd1;
            end
         end
         S_CROSS: begin
            v_ff[0]  <= b0;
            v_ff[1]  <= b1;
            v_ff[2]  <= b2;
            which_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign ready = ok_ff;
   assign basis = '{ax_x: ax_ff[0], ax_y: ax_ff[1], ax_z: ax_ff[2],
                    ay_x: ay_ff[0], ay_y: ay_ff[1], ay_z: ay_ff[2]};

   `CPIP_ASSERT_NXT(a_cfg_restarts, clock, reset, cfg_write, !ok_ff)
   `CPIP_ASSERT_IMP(a_div_rem_below, clock, reset, state_ff == S_DIV, rem_ff < len_w)
   `CPIP_ASSERT_IMP(a_sqrt_bit_hot, clock, reset, state_ff == S_SQRT, $onehot(bit_ff))

endmodule

### sv/cpip_axis_lane.sv
// One coordinate lane: scales cos/sin terms by the basis, adds center, saturates (zero forces 0).
// Depends on cpip_pkg.
module cpip_axis_lane
   import cpip_pkg::*;
(
   input  logic                      clock,
   input  logic signed [RC_W-1:0]    rc,
   input  logic signed [RC_W-1:0]    rs,
   input  logic signed [UNIT_W-1:0]  ax,
   input  logic signed [UNIT_W-1:0]  ay,
   input  logic signed [COORD_W-1:0] center,
   input  logic                      zero,
   output logic signed [COORD_W-1:0] point
);

   localparam logic signed [TPROD_W-1:0] HALF = 69'sd536870912;
   localparam logic signed [SUM_W-1:0]   SMAX = 41'sd2147483647;
   localparam logic signed [SUM_W-1:0]   SMIN = -41'sd2147483648;

   logic signed [TPROD_W-1:0] pc_ff, ps_ff, rpc, rps;
   logic signed [TERM_W-1:0]  tc_ff, ts_ff;
   logic signed [SUM_W-1:0]   sum;
   logic signed [COORD_W-1:0] point_ff, point_in;

   always_comb begin
      rpc = pc_ff + HALF;
      rps = ps_ff + HALF;
      sum = SUM_W'(center) + SUM_W'(tc_ff) + SUM_W'(ts_ff);
      if (zero) point_in = '0;
      else if (sum > SMAX) point_in = SMAX[COORD_W-1:0];
      else if (sum < SMIN) point_in = SMIN[COORD_W-1:0];
      else point_in = sum[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      pc_ff    <= rc * ax;
      ps_ff    <= rs * ay;
      tc_ff    <= rpc[TPROD_W-1:30];
      ts_ff    <= rps[TPROD_W-1:30];
      point_ff <= point_in;
   end

   assign point = point_ff;

endmodule

### sv/circle_point_in_plane.sv
// Top level of the circle point block: config registers, CORDIC cell chain,
// radius scaling and three coordinate lanes. Depends on cpip_pkg and the cpip_ modules.
//
//   channel | ports                               | handshake
//   req     | start, busy, req_angle_turns        | word taken when start & !busy
//   rsp     | rsp_valid, rsp_point_*              | one-cycle strobe, no back pressure
//   csr     | csr_valid, csr_ready, csr_index/data| word taken when valid & ready
//
// One angle per cycle while busy is low; the path holds an entry register, one per
// CORDIC cell, two for radius scaling and three in the lanes.
// After reset and after every csr word the basis sequencer runs (square root and
// bit-serial divide per unit vector); busy is high then.
// The receiver cannot stall, so nothing downstream holds the pipeline.
module circle_point_in_plane
   import cpip_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [ANGLE_W-1:0]        req_angle_turns,
   output logic                      rsp_valid,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic signed [COORD_W-1:0] rsp_point_z,
   output logic                      rsp_point_valid,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_data
);

   localparam logic signed [PROD_W-1:0] HALF = 67'sd536870912;

   logic signed [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic signed [NORM_W-1:0]  nx_ff, ny_ff, nz_ff;
   logic [31:0]               radius_ff;
   logic                      csr_wr, accept, basis_ok;
   basis_type                 basis;

   cordic_type chain [CORDIC_STAGES+1];
   cordic_type ent_in;
   logic                      ent_vld_ff;
   logic [1:0]                ent_quad_ff;
   logic signed [PHASE_W-1:0] ent_z_ff;
   logic [ANGLE_W-1:0]        a_rot;
   logic [1:0]                quad;
   logic signed [ANGLE_W-1:0] dlt;

   logic signed [CORD_W-1:0]  cosv, sinv;
   logic signed [32:0]        r33;
   logic signed [PROD_W-1:0]  pc_ff, ps_ff, rpc, rps;
   logic signed [RC_W-1:0]    rc_ff, rs_ff;
   logic [4:0]                vpipe_ff;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign busy      = !basis_ok;
   assign accept    = start & !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         cz_ff     <= '0;
         nx_ff     <= '0;
         ny_ff     <= '0;
         nz_ff     <= 16'sd16384;
         radius_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_CENTER_X: cx_ff     <= csr_data;
            CSR_CENTER_Y: cy_ff     <= csr_data;
            CSR_CENTER_Z: cz_ff     <= csr_data;
            CSR_NORMAL_X: nx_ff     <= csr_data[NORM_W-1:0];
            CSR_NORMAL_Y: ny_ff     <= csr_data[NORM_W-1:0];
            CSR_NORMAL_Z: nz_ff     <= csr_data[NORM_W-1:0];
            CSR_RADIUS:   radius_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   cpip_basis u_basis (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (csr_wr),
      .nx        (nx_ff),
      .ny        (ny_ff),
      .nz        (nz_ff),
      .basis     (basis),
      .ready     (basis_ok)
   );

   always_comb begin
      a_rot = req_angle_turns + 16'h2000;
      quad  = a_rot[15:14];
      dlt   = $signed(req_angle_turns - {quad, 14'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
      end else begin
         ent_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      ent_quad_ff <= quad;
      ent_z_ff    <= {dlt, 16'b0};
   end

   assign ent_in   = '{vld: ent_vld_ff, quad: ent_quad_ff, x: INV_GAIN, y: '0, z: ent_z_ff};
   assign chain[0] = ent_in;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      cpip_cordic_cell #(.SHIFT(g)) u_cell (
         .clock (clock),
         .reset (reset),
         .d_in  (chain[g]),
         .d_out (chain[g+1])
      );
   end

   always_comb begin
      case (chain[CORDIC_STAGES].quad)
         2'd0: begin
            cosv = chain[CORDIC_STAGES].x;
            sinv = chain[CORDIC_STAGES].y;
         end
         2'd1: begin
            cosv = -chain[CORDIC_STAGES].y;
            sinv = chain[CORDIC_STAGES].x;
         end
         2'd2: begin
            cosv = -chain[CORDIC_STAGES].x;
            sinv = -chain[CORDIC_STAGES].y;
         end
         default: begin
            cosv = chain[CORDIC_STAGES].y;
            sinv = -chain[CORDIC_STAGES].x;
         end
      endcase
      r33 = $signed({1'b0, radius_ff});
      rpc = pc_ff + HALF;
      rps = ps_ff + HALF;
   end

   always_ff @(posedge clock) begin
      pc_ff <= r33 * cosv;
      ps_ff <= r33 * sinv;
      rc_ff <= rpc[PROD_W-1:30];
      rs_ff <= rps[PROD_W-1:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vpipe_ff <= '0;
      end else begin
         vpipe_ff <= {vpipe_ff[3:0], chain[CORDIC_STAGES].vld};
      end
   end

   cpip_axis_lane u_lane_x (
      .clock (clock), .rc (rc_ff), .rs (rs_ff), .ax (basis.ax_x), .ay (basis.ay_x),
      .center (cx_ff), .zero (radius_ff == '0), .point (rsp_point_x)
   );

   cpip_axis_lane u_lane_y (
      .clock (clock), .rc (rc_ff), .rs (rs_ff), .ax (basis.ax_y), .ay (basis.ay_y),
      .center (cy_ff), .zero (radius_ff == '0), .point (rsp_point_y)
   );

   cpip_axis_lane u_lane_z (
      .clock (clock), .rc (rc_ff), .rs (rs_ff), .ax (basis.ax_z), .ay (basis.ay_z),
      .center (cz_ff), .zero (radius_ff == '0), .point (rsp_point_z)
   );

   assign rsp_valid       = vpipe_ff[4];
   assign rsp_point_valid = (radius_ff != '0);

endmodule

### tb/tb_top.sv
// Self-checking testbench of circle_point_in_plane: angle words are streamed under a
// range of center, normal and radius settings, and each point is checked against a
// built-in integer model. Depends on cpip_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top
   import cpip_pkg::*;
();

   localparam int STAGES = 16;
   localparam int DRAIN_CYCLES = STAGES + 14;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam longint ONE30 = 64'sd1073741824;
   localparam longint HALF30 = 64'sd536870912;
   localparam longint INV_GAIN_Q30 = 64'sd652032874;
   localparam longint ARCTAN [16] = '{536870912, 316933406, 167458907, 85004756,
      42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      v;
   } point_type;

   logic clock, reset, start, busy, rsp_valid, rsp_point_valid;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_data;
   logic [ANGLE_W-1:0] req_angle_turns;
   logic signed [COORD_W-1:0] rsp_point_x, rsp_point_y, rsp_point_z;

   logic [ANGLE_W-1:0] angle_pending [$];
   point_type          point_expected [$];
   int                 error_count = 0;
   int                 issued = 0;
   bit                 taken = 0;

   longint cen [3];
   longint nrm [3];
   longint unsigned rad;

   circle_point_in_plane #(.CORDIC_STAGES(STAGES)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_angle_turns(req_angle_turns), .rsp_valid(rsp_valid),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z),
      .rsp_point_valid(rsp_point_valid), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned isqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic void to_unit(input longint v [3], output longint u [3],
                                   input int fallback);
      longint unsigned m [3];
      longint unsigned mx, l2, len;
      longint q;
      mx = 0;
      l2 = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) u[i] = (i == fallback) ? ONE30 : 0;
         return;
      end
      while (mx < (64'd1 << 30)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      if (mx >= (64'd1 << 31))
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      for (int i = 0; i < 3; i++) l2 += m[i] * m[i];
      len = isqrt(l2);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
         q = longint'((m[i] << 30) / len);
         u[i] = v[i] < 0 ? -q : q;
      end
   endfunction

   function automatic void plane_axes(output longint ax [3], output longint ay [3]);
      longint nx, ny, nz;
      longint a [3];
      longint b [3];
      longint unsigned l2, z2;
      nx = nrm[0];
      ny = nrm[1];
      nz = nrm[2];
      if (nx == 0 && ny == 0 && nz == 0) nz = 1;
      if (nx == 0 && ny == 0) begin
         ax = '{ONE30, 0, 0};
         b = '{0, nz, 0};
         to_unit(b, ay, 1);
         return;
      end
      l2 = nx * nx + ny * ny + nz * nz;
      z2 = nz * nz;
      if (z2 * 1000000 < l2 * 998001) a = '{-ny, nx, 0};
      else a = '{nz, 0, -nx};
      to_unit(a, ax, 0);
      b[0] = ny * a[2] - nz * a[1];
      b[1] = nz * a[0] - nx * a[2];
      b[2] = nx * a[1] - ny * a[0];
      to_unit(b, ay, 1);
   endfunction

   function automatic void cos_sin(input logic [ANGLE_W-1:0] ang,
                                   output longint c, output longint s);
      logic [1:0] quad;
      logic [15:0] dbits;
      longint x, y, z, t, d;
      quad = 2'((17'(ang) + 17'h2000) >> 14);
      dbits = ang - {quad, 14'd0};
      d = longint'($signed(dbits));
      x = INV_GAIN_Q30;
      y = 0;
      z = d * 65536;
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
         end else begin
            t = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
         end
         x = t;
      end
      case (quad)
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic point_type circle_point(input logic [ANGLE_W-1:0] ang);
      point_type pt;
      longint ax [3];
      longint ay [3];
      longint c, s, rc, rs, p;
      longint sum [3];
      pt = '{0, 0, 0, 1'b0};
      if (rad == 0) return pt;
      plane_axes(ax, ay);
      cos_sin(ang, c, s);
      rc = (longint'(rad) * c + HALF30) >>> 30;
      rs = (longint'(rad) * s + HALF30) >>> 30;
      for (int i = 0; i < 3; i++) begin
         p = cen[i] + ((rc * ax[i] + HALF30) >>> 30) + ((rs * ay[i] + HALF30) >>> 30);
         if (p > 64'sd2147483647) p = 64'sd2147483647;
         if (p < -64'sd2147483648) p = -64'sd2147483648;
         sum[i] = p;
      end
      pt.x = sum[0][31:0];
      pt.y = sum[1][31:0];
      pt.z = sum[2][31:0];
      pt.v = 1'b1;
      return pt;
   endfunction

   // accepted angles and result words, sampled at the rising edge
   always @(posedge clock) begin
      point_type want;
      taken = start && !busy && !reset;
      if (taken) point_expected.push_back(circle_point(req_angle_turns));
      if (rsp_valid && !reset) begin
         if (point_expected.size() == 0) begin
            $display("%0t: unexpected word x=%0d y=%0d z=%0d v=%0b", $time,
                     rsp_point_x, rsp_point_y, rsp_point_z, rsp_point_valid);
            error_count++;
         end else begin
            want = point_expected.pop_front();
            if (want.x !== rsp_point_x || want.y !== rsp_point_y ||
                want.z !== rsp_point_z || want.v !== rsp_point_valid) begin
               $display("%0t: mismatch expected x=%0d y=%0d z=%0d v=%0b", $time,
                        want.x, want.y, want.z, want.v);
               $display("%0t:          actual   x=%0d y=%0d z=%0d v=%0b", $time,
                        rsp_point_x, rsp_point_y, rsp_point_z, rsp_point_valid);
               error_count++;
            end
         end
      end
   end

   // angle driver: holds start until taken, random gaps except in a back-to-back stretch
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (angle_pending.size() != 0 &&
             ((issued >= 150 && issued < 260) || $urandom_range(0, 99) >= 22)) begin
            req_angle_turns <= angle_pending.pop_front();
            start <= 1'b1;
            issued++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CENTER_X: cen[0] = longint'($signed(data));
         CSR_CENTER_Y: cen[1] = longint'($signed(data));
         CSR_CENTER_Z: cen[2] = longint'($signed(data));
         CSR_NORMAL_X: nrm[0] = longint'($signed(data[15:0]));
         CSR_NORMAL_Y: nrm[1] = longint'($signed(data[15:0]));
         CSR_NORMAL_Z: nrm[2] = longint'($signed(data[15:0]));
         CSR_RADIUS:   rad = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (angle_pending.size() != 0 || start || point_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic setup(input logic [31:0] cx, cy, cz, input logic [15:0] nx, ny, nz,
                        input logic [31:0] r);
      drain();
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_CENTER_Z, cz);
      write_reg(CSR_NORMAL_X, {16'(nx)});
      write_reg(CSR_NORMAL_Y, {16'($urandom_range(0, 65535)), ny});
      write_reg(CSR_NORMAL_Z, {16'(nz)});
      write_reg(CSR_RADIUS, r);
   endtask

   initial begin
      logic [15:0] nx, ny, nz;
      logic [31:0] r;
      reset = 1'b1;
      start = 1'b0;
      req_angle_turns = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cen = '{0, 0, 0};
      nrm = '{0, 0, 16384};
      rad = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero radius after reset
      angle_pending = '{16'h0000, 16'hFFFF};
      setup(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 32'h0001_0000);
      angle_pending = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000, 16'h6000, 16'h8000,
                        16'hC000, 16'hE000, 16'hFFFF};
      setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'h8000, 16'h7FFF, 16'h0001,
            32'hFFFF_FFFF);
      angle_pending = '{16'h2000, 16'hA000, 16'h5555};
      setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 16'h0000, 16'h8000,
            32'h0000_0001);
      angle_pending = '{16'h1234, 16'hC000};
      setup(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0001, 16'h0000, 16'h7FFF,
            32'h0010_0000);
      angle_pending = '{16'h4000, 16'hDEAD};
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      angle_pending.push_back(16'h7777);
      angle_pending.push_back(16'h0001);

      for (int ph = 0; ph < 12; ph++) begin
         drain();
         case ($urandom_range(0, 5))
            0: begin nx = 0; ny = 0; nz = 0; end
            1: begin nx = 0; ny = 0; nz = 16'($urandom); end
            2: begin
               nx = 16'($urandom_range(0, 40) - 20);
               ny = 16'($urandom_range(0, 40) - 20);
               nz = $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(0, 99))
                                         : 16'(16'h8000 + $urandom_range(0, 99));
            end
            3: begin nx = 16'h8000; ny = 16'h8000; nz = 16'h8000; end
            default: begin
               nx = 16'($urandom);
               ny = 16'($urandom);
               nz = 16'($urandom);
            end
         endcase
         case ($urandom_range(0, 5))
            0: r = 32'd0;
            1: r = 32'hFFFF_FFFF;
            2: r = $urandom_range(1, 65536);
            default: r = $urandom;
         endcase
         for (int i = 0; i < 45; i++) angle_pending.push_back(16'($urandom));
         setup($urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : $urandom,
               $urandom, $urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom,
               nx, ny, nz, r);
      end
      drain();
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #3ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
